// ===== hw/rtl/ctu_pkg.sv =====
// ----------------------------------------------------------------------------
// ctu_pkg: shared types and constants of the TCP connection tracker
// Header field codes, connection state and status codes, result outcome
// codes and the structs passed between the table cells and the top level.
// ----------------------------------------------------------------------------
package ctu_pkg;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] FLAG_FIN   = 8'h01;
   localparam logic [7:0] FLAG_SYN   = 8'h02;
   localparam logic [7:0] FLAG_ACK   = 8'h10;
   localparam logic [7:0] FLAG_MASK  = FLAG_FIN | FLAG_SYN | FLAG_ACK;

   localparam logic [6:0] RETRY_MAX         = 7'd127;
   localparam logic [6:0] RETRY_LIMIT_RESET = 7'd6;
   localparam int         SLOT_W            = 6;

   typedef enum logic [2:0] {
      ST_UNKNOWN = 3'd0,
      ST_SYN     = 3'd1,
      ST_SYNACK  = 3'd2,
      ST_ACK     = 3'd3,
      ST_FIN1    = 3'd4,
      ST_FIN2    = 3'd5
   } conn_state_type;

   typedef enum logic [2:0] {
      CS_UNKNOWN       = 3'd0,
      CS_CONNECTING    = 3'd1,
      CS_CONNECTED     = 3'd2,
      CS_FAILED        = 3'd3,
      CS_DISCONNECTING = 3'd4,
      CS_DISCONNECTED  = 3'd5
   } conn_status_type;

   typedef enum logic [3:0] {
      OC_IGNORED   = 4'd0,
      OC_CREATED   = 4'd1,
      OC_RETRY     = 4'd2,
      OC_FAILED    = 4'd3,
      OC_ADVANCED  = 4'd4,
      OC_EVICTED   = 4'd5,
      OC_CONNECTED = 4'd6,
      OC_CLOSED    = 4'd7,
      OC_NOCHANGE  = 4'd8,
      OC_NOTFOUND  = 4'd9,
      OC_FULL      = 4'd10
   } outcome_type;

   // connection key, ordered source then destination
   typedef struct packed {
      logic [31:0] sa;
      logic [15:0] sp;
      logic [31:0] da;
      logic [15:0] dp;
   } tuple_type;

   typedef struct packed {
      conn_state_type  state;
      conn_status_type status;
      logic [6:0]      retries;
      logic [7:0]      flags;
   } entry_type;

   // write word broadcast to the table cells
   typedef struct packed {
      logic      load_key;
      logic      valid_next;
      tuple_type key;
      entry_type data;
   } wr_cmd_type;

   typedef struct packed {
      outcome_type       outcome;
      logic [SLOT_W-1:0] slot;
      logic              reversed;
      entry_type         data;
   } result_type;

endpackage

// ===== hw/rtl/ctu_prienc.sv =====
// ----------------------------------------------------------------------------
// ctu_prienc: lowest-index priority encoder
// Reports whether any request bit is set and the index of the lowest one.
// ----------------------------------------------------------------------------
module ctu_prienc #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         req,
   output logic                     hit,
   output logic [$clog2(WIDTH)-1:0] idx
);

   localparam int IDX_W = $clog2(WIDTH);

   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (req[i]) begin
            hit = 1'b1;
            idx = IDX_W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/ctu_cell.sv =====
// ----------------------------------------------------------------------------
// ctu_cell: one connection table slot
// Holds the valid bit, key and connection data of one slot and matches the
// key against the forward and the swapped packet tuple.
// ----------------------------------------------------------------------------
module ctu_cell import ctu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  wr_cmd_type wr_cmd,
   input  tuple_type  fwd_key,
   input  tuple_type  rev_key,
   output logic       vld,
   output logic       hit_fwd,
   output logic       hit_rev,
   output entry_type  ent
);

   logic      valid_ff;
   tuple_type key_ff;
   entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= wr_cmd.valid_next;
      end
   end

   // key and data carry no reset: only read while valid
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ent_ff <= wr_cmd.data;
         if (wr_cmd.load_key) begin
            key_ff <= wr_cmd.key;
         end
      end
   end

   assign vld     = valid_ff;
   assign hit_fwd = valid_ff && (key_ff == fwd_key);
   assign hit_rev = valid_ff && (key_ff == rev_key);
   assign ent     = ent_ff;

endmodule

// ===== hw/rtl/tcp_connection_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit: TCP connection table with parallel tuple match
// Tracks SYN / SYN+ACK / ACK / FIN handshakes per connection in a table of
// ENTRIES slots and answers one result word per packet header word.
// ----------------------------------------------------------------------------
// Takes one header word per clock (start high, busy low) and returns exactly
// one result word for each, in order, with rsp_valid high for one cycle. The
// receiver cannot stall, and busy is high only while reset is held. The rate
// is set by the combinational match: every slot compares its key to the
// forward and swapped tuple at once, priority encoders pick the lowest hit
// and the lowest free slot, and the update is written back in that same
// cycle, so the next word sees the new table. Valid bits clear at reset;
// there is no clearing pass. The user must write the retry limit through
// csr_valid/csr_data (always ready) only while idle; the unit does not check.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_unit import ctu_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // header words
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_tcp_flags,
   // result words
   output logic        rsp_valid,
   output logic [3:0]  rsp_outcome,
   output logic [5:0]  rsp_slot,
   output logic        rsp_matched_reversed,
   output logic [2:0]  rsp_conn_state,
   output logic [2:0]  rsp_conn_status,
   output logic [6:0]  rsp_retry_count,
   output logic [7:0]  rsp_stored_flags,
   // retry limit register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   // ---------------- config register ----------------
   logic [6:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   // ---------------- input register ----------------
   logic        in_vld_ff;
   logic [7:0]  proto_ff;
   logic [31:0] sa_ff;
   logic [31:0] da_ff;
   logic [15:0] sp_ff;
   logic [15:0] dp_ff;
   logic [7:0]  flags_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         proto_ff <= req_ip_protocol;
         sa_ff    <= req_src_addr;
         da_ff    <= req_dst_addr;
         sp_ff    <= req_src_port;
         dp_ff    <= req_dst_port;
         flags_ff <= req_tcp_flags;
      end
   end

   // ---------------- table ----------------
   tuple_type            fwd_key;
   tuple_type            rev_key;
   logic [ENTRIES-1:0]   fwd_vec;
   logic [ENTRIES-1:0]   rev_vec;
   logic [ENTRIES-1:0]   vld_vec;
   entry_type            cell_ent [ENTRIES];
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_slot;
   wr_cmd_type           wr_cmd;

   assign fwd_key = '{sa: sa_ff, sp: sp_ff, da: da_ff, dp: dp_ff};
   assign rev_key = '{sa: da_ff, sp: dp_ff, da: sa_ff, dp: sp_ff};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ctu_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr_en && (wr_slot == IDX_W'(i))),
         .wr_cmd  (wr_cmd),
         .fwd_key (fwd_key),
         .rev_key (rev_key),
         .vld     (vld_vec[i]),
         .hit_fwd (fwd_vec[i]),
         .hit_rev (rev_vec[i]),
         .ent     (cell_ent[i])
      );
   end

   logic             fwd_hit;
   logic             rev_hit;
   logic             free_hit;
   logic [IDX_W-1:0] fwd_idx;
   logic [IDX_W-1:0] rev_idx;
   logic [IDX_W-1:0] free_idx;

   ctu_prienc #(.WIDTH(ENTRIES)) u_enc_fwd (.req(fwd_vec),  .hit(fwd_hit),  .idx(fwd_idx));
   ctu_prienc #(.WIDTH(ENTRIES)) u_enc_rev (.req(rev_vec),  .hit(rev_hit),  .idx(rev_idx));
   ctu_prienc #(.WIDTH(ENTRIES)) u_enc_free (.req(~vld_vec), .hit(free_hit), .idx(free_idx));

   // ---------------- decision ----------------
   logic [7:0]       m;
   logic             is_tcp;
   logic             is_syn;
   logic             is_synack;
   logic             is_ack;
   logic             is_fin;
   logic             look_hit;
   logic             look_rev;
   logic [IDX_W-1:0] look_idx;
   entry_type        sel;
   logic [6:0]       ret_inc;
   result_type       res;

   always_comb begin
      m         = flags_ff & FLAG_MASK;
      is_tcp    = in_vld_ff && (proto_ff == PROTO_TCP);
      is_syn    = is_tcp && (m == FLAG_SYN);
      is_synack = is_tcp && (m == (FLAG_SYN | FLAG_ACK));
      is_ack    = is_tcp && (m == FLAG_ACK);
      is_fin    = is_tcp && ((m == FLAG_FIN) || (m == (FLAG_FIN | FLAG_ACK)));

      // which lookup applies: SYN forward only, SYN+ACK swapped only,
      // ACK and FIN forward first then swapped
      priority if (is_syn) begin
         look_hit = fwd_hit;
         look_rev = 1'b0;
         look_idx = fwd_idx;
      end else if (is_synack) begin
         look_hit = rev_hit;
         look_rev = 1'b1;
         look_idx = rev_idx;
      end else if (fwd_hit) begin
         look_hit = 1'b1;
         look_rev = 1'b0;
         look_idx = fwd_idx;
      end else begin
         look_hit = rev_hit;
         look_rev = 1'b1;
         look_idx = rev_idx;
      end

      sel     = cell_ent[look_idx];
      ret_inc = (sel.retries == RETRY_MAX) ? sel.retries : sel.retries + 7'd1;

      wr_en             = 1'b0;
      wr_slot           = look_idx;
      wr_cmd.load_key   = 1'b0;
      wr_cmd.valid_next = 1'b1;
      wr_cmd.key        = fwd_key;
      wr_cmd.data       = sel;
      res               = '0;

      if (is_syn || is_synack || is_ack || is_fin) begin
         if (look_hit) begin
            res.slot     = SLOT_W'(look_idx);
            res.reversed = look_rev;
            res.outcome  = OC_ADVANCED;
            wr_en        = 1'b1;
            priority if (is_syn) begin
               wr_cmd.data.retries = ret_inc;
               wr_cmd.data.flags   = flags_ff;
               if (ret_inc >= limit_ff) begin
                  wr_cmd.data.status = CS_FAILED;
                  res.outcome        = OC_FAILED;
               end else begin
                  res.outcome = OC_RETRY;
               end
            end else if (is_synack) begin
               if (sel.state == ST_SYN) begin
                  wr_cmd.data.flags  = flags_ff;
                  wr_cmd.data.state  = ST_SYNACK;
                  wr_cmd.data.status = CS_CONNECTING;
               end else begin
                  // out-of-order SYN+ACK drops the entry
                  wr_cmd.data.state = ST_UNKNOWN;
                  wr_cmd.valid_next = 1'b0;
                  res.outcome       = OC_EVICTED;
               end
            end else if (is_ack) begin
               if (sel.state == ST_SYNACK) begin
                  wr_cmd.data.flags  = flags_ff;
                  wr_cmd.data.state  = ST_ACK;
                  wr_cmd.data.status = CS_CONNECTED;
                  res.outcome        = OC_CONNECTED;
               end else if (sel.state == ST_FIN2) begin
                  wr_cmd.data.flags   = flags_ff;
                  wr_cmd.data.state   = ST_ACK;
                  wr_cmd.data.status  = CS_DISCONNECTED;
                  wr_cmd.data.retries = '0;
                  wr_cmd.valid_next   = 1'b0;
                  res.outcome         = OC_CLOSED;
               end else begin
                  wr_en       = 1'b0;
                  res.outcome = OC_NOCHANGE;
               end
            end else begin
               wr_cmd.data.state  = (sel.state == ST_FIN1) ? ST_FIN2 : ST_FIN1;
               wr_cmd.data.flags  = flags_ff;
               wr_cmd.data.status = CS_DISCONNECTING;
            end
            res.data = wr_cmd.data;
         end else if (is_ack) begin
            res.outcome = OC_NOTFOUND;
         end else if (free_hit) begin
            // new connection in the lowest free slot
            wr_en                = 1'b1;
            wr_slot              = free_idx;
            wr_cmd.load_key      = 1'b1;
            wr_cmd.key           = is_syn ? fwd_key : rev_key;
            wr_cmd.data.retries  = '0;
            wr_cmd.data.flags    = flags_ff;
            priority if (is_syn) begin
               wr_cmd.data.state  = ST_SYN;
               wr_cmd.data.status = CS_CONNECTING;
            end else if (is_synack) begin
               wr_cmd.data.state  = ST_SYNACK;
               wr_cmd.data.status = CS_CONNECTING;
            end else begin
               wr_cmd.data.state  = ST_FIN1;
               wr_cmd.data.status = CS_DISCONNECTING;
            end
            res.outcome  = OC_CREATED;
            res.slot     = SLOT_W'(free_idx);
            res.reversed = !is_syn;
            res.data     = wr_cmd.data;
         end else begin
            res.outcome = OC_FULL;
         end
      end
   end

   // ---------------- result register ----------------
   logic       rsp_vld_ff;
   result_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_outcome          = rsp_ff.outcome;
   assign rsp_slot             = rsp_ff.slot;
   assign rsp_matched_reversed = rsp_ff.reversed;
   assign rsp_conn_state       = rsp_ff.data.state;
   assign rsp_conn_status      = rsp_ff.data.status;
   assign rsp_retry_count      = rsp_ff.data.retries;
   assign rsp_stored_flags     = rsp_ff.data.flags;

   // ---------------- assertions ----------------
`ifndef SYNTHESIS
   // every accepted word yields its result after the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   // no-entry results carry zeros in every other field
   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome == OC_IGNORED || rsp_outcome == OC_NOTFOUND ||
                     rsp_outcome == OC_FULL))
      |-> (rsp_slot == '0 && !rsp_matched_reversed && rsp_conn_state == ST_UNKNOWN &&
           rsp_conn_status == CS_UNKNOWN && rsp_retry_count == '0 &&
           rsp_stored_flags == '0))
      else $error("non-zero fields on untouched result");

   // a close reports the final state with retries cleared
   a_close_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OC_CLOSED)
      |-> (rsp_conn_state == ST_ACK && rsp_conn_status == CS_DISCONNECTED &&
           rsp_retry_count == '0))
      else $error("close result with wrong final values");

   // a new entry is only written into a free slot
   a_full_no_free: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_cmd.load_key) |-> !vld_vec[free_idx])
      else $error("create into an occupied slot");
`endif

endmodule

// ===== test/tcp_connection_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit_tb: self-checking bench for the connection table
// Feeds packet header words through start/busy, keeps its own copy of the
// connection table to predict every result word, and checks each rsp_valid
// word field by field. Directed handshakes first, then randomized traffic
// under several retry limits and sender idle rates.
// ----------------------------------------------------------------------------
module tcp_connection_tracker_unit_tb import ctu_pkg::*;;

   localparam int SLOTS         = 64;
   localparam int LATENCY       = 2;      // delay from accept to rsp_valid
   localparam int SETTLE_CYCLES = LATENCY + 4;
   localparam int QUIET_LIMIT   = 5000;   // cycles with no handshake at all
   localparam bit FWD           = 1'b0;   // send the tuple as stored
   localparam bit REV           = 1'b1;   // send it with ends swapped

   // one packet header word plus a bench-only hold-off flag
   typedef struct {
      logic [7:0]  proto;
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [7:0]  flags;
      bit          drain_first;   // send only once every result is back
   } hdr_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_ip_protocol = '0;
   logic [31:0] req_src_addr    = '0;
   logic [31:0] req_dst_addr    = '0;
   logic [15:0] req_src_port    = '0;
   logic [15:0] req_dst_port    = '0;
   logic [7:0]  req_tcp_flags   = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_outcome;
   logic [5:0]  rsp_slot;
   logic        rsp_matched_reversed;
   logic [2:0]  rsp_conn_state;
   logic [2:0]  rsp_conn_status;
   logic [6:0]  rsp_retry_count;
   logic [7:0]  rsp_stored_flags;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data  = '0;

   // bench copy of the connection table and the retry limit
   bit          conn_valid [SLOTS];
   tuple_type   conn_key   [SLOTS];
   entry_type   conn_data  [SLOTS];
   logic [6:0]  retry_limit = RETRY_LIMIT_RESET;

   hdr_word_type hdr_backlog[$];        // words not yet on the wire
   result_type   predicted_results[$];  // one per accepted word, oldest first
   hdr_word_type on_wire;
   result_type   due;

   int send_idle_pct = 0;
   int error_count   = 0;
   int words_in      = 0;
   int results_seen  = 0;
   int limit_writes  = 0;
   int drain_pauses  = 0;
   int quiet_cycles  = 0;
   int outcome_hits [11];

   always #2 clock = ~clock;

   tcp_connection_tracker_unit #(
      .ENTRIES (SLOTS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_ip_protocol      (req_ip_protocol),
      .req_src_addr         (req_src_addr),
      .req_dst_addr         (req_dst_addr),
      .req_src_port         (req_src_port),
      .req_dst_port         (req_dst_port),
      .req_tcp_flags        (req_tcp_flags),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_slot             (rsp_slot),
      .rsp_matched_reversed (rsp_matched_reversed),
      .rsp_conn_state       (rsp_conn_state),
      .rsp_conn_status      (rsp_conn_status),
      .rsp_retry_count      (rsp_retry_count),
      .rsp_stored_flags     (rsp_stored_flags),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   // ------------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------------

   // lowest valid slot holding this key, -1 if none
   function automatic int find_conn(tuple_type key);
      for (int i = 0; i < SLOTS; i++) begin
         if (conn_valid[i] && conn_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic result_type snapshot(outcome_type oc, int idx, bit rev);
      result_type r;
      r.outcome  = oc;
      r.slot     = 6'(idx);
      r.reversed = rev;
      r.data     = conn_data[idx];
      return r;
   endfunction

   // new entry in the lowest free slot; full table stores nothing
   function automatic result_type open_conn(tuple_type key, conn_state_type st,
                                            conn_status_type cs, logic [7:0] flags,
                                            bit rev);
      result_type r;
      for (int i = 0; i < SLOTS; i++) begin
         if (!conn_valid[i]) begin
            conn_valid[i] = 1'b1;
            conn_key[i]   = key;
            conn_data[i]  = '{state: st, status: cs, retries: 7'd0, flags: flags};
            return snapshot(OC_CREATED, i, rev);
         end
      end
      r         = '0;
      r.outcome = OC_FULL;
      return r;
   endfunction

   // next table state and result word for one accepted header word
   function automatic result_type track_header(hdr_word_type w);
      tuple_type  fwd;
      tuple_type  swp;
      logic [7:0] kind;
      int         hit;
      bit         rev;
      result_type res;
      fwd  = '{sa: w.sa, sp: w.sp, da: w.da, dp: w.dp};
      swp  = '{sa: w.da, sp: w.dp, da: w.sa, dp: w.sp};
      kind = w.flags & FLAG_MASK;
      res  = '0;
      rev  = 1'b0;
      if (w.proto != PROTO_TCP) return res;
      case (kind)
         FLAG_SYN: begin
            hit = find_conn(fwd);
            if (hit < 0) return open_conn(fwd, ST_SYN, CS_CONNECTING, w.flags, 1'b0);
            // retry count saturates; state is left alone
            if (conn_data[hit].retries != RETRY_MAX)
               conn_data[hit].retries = conn_data[hit].retries + 7'd1;
            conn_data[hit].flags = w.flags;
            if (conn_data[hit].retries >= retry_limit) begin
               conn_data[hit].status = CS_FAILED;
               return snapshot(OC_FAILED, hit, 1'b0);
            end
            return snapshot(OC_RETRY, hit, 1'b0);
         end
         FLAG_SYN | FLAG_ACK: begin
            hit = find_conn(swp);
            if (hit < 0) return open_conn(swp, ST_SYNACK, CS_CONNECTING, w.flags, 1'b1);
            if (conn_data[hit].state == ST_SYN) begin
               conn_data[hit].flags  = w.flags;
               conn_data[hit].state  = ST_SYNACK;
               conn_data[hit].status = CS_CONNECTING;
               return snapshot(OC_ADVANCED, hit, 1'b1);
            end
            // out-of-order SYN+ACK drops the entry, old status shown
            conn_data[hit].state = ST_UNKNOWN;
            res = snapshot(OC_EVICTED, hit, 1'b1);
            conn_valid[hit] = 1'b0;
         end
         FLAG_ACK: begin
            hit = find_conn(fwd);
            if (hit < 0) begin
               hit = find_conn(swp);
               rev = 1'b1;
            end
            if (hit < 0) begin
               res.outcome = OC_NOTFOUND;
               return res;
            end
            if (conn_data[hit].state == ST_SYNACK) begin
               conn_data[hit].flags  = w.flags;
               conn_data[hit].state  = ST_ACK;
               conn_data[hit].status = CS_CONNECTED;
               return snapshot(OC_CONNECTED, hit, rev);
            end
            if (conn_data[hit].state == ST_FIN2) begin
               conn_data[hit].flags   = w.flags;
               conn_data[hit].state   = ST_ACK;
               conn_data[hit].status  = CS_DISCONNECTED;
               conn_data[hit].retries = 7'd0;
               res = snapshot(OC_CLOSED, hit, rev);
               conn_valid[hit] = 1'b0;
               return res;
            end
            return snapshot(OC_NOCHANGE, hit, rev);
         end
         FLAG_FIN, FLAG_FIN | FLAG_ACK: begin
            hit = find_conn(fwd);
            if (hit < 0) begin
               hit = find_conn(swp);
               rev = 1'b1;
            end
            if (hit < 0) return open_conn(swp, ST_FIN1, CS_DISCONNECTING, w.flags, 1'b1);
            // FIN toggles between the two closing states
            if (conn_data[hit].state == ST_FIN1) begin
               conn_data[hit].state = ST_FIN2;
            end else begin
               conn_data[hit].state = ST_FIN1;
            end
            conn_data[hit].flags  = w.flags;
            conn_data[hit].status = CS_DISCONNECTING;
            return snapshot(OC_ADVANCED, hit, rev);
         end
         default: ;   // any other flag mix is ignored
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------

   function automatic tuple_type random_tuple();
      return '{sa: $urandom, sp: 16'($urandom), da: $urandom, dp: 16'($urandom)};
   endfunction

   // flag bits outside FIN/SYN/ACK only ride along
   function automatic logic [7:0] spare_flag_bits();
      return 8'($urandom) & ~FLAG_MASK;
   endfunction

   function automatic logic [7:0] fin_kind();
      return $urandom_range(1) ? FLAG_FIN : (FLAG_FIN | FLAG_ACK);
   endfunction

   function automatic void queue_packet(logic [7:0] proto, tuple_type t, bit swap,
                                        logic [7:0] flags);
      hdr_word_type w;
      w.proto       = proto;
      w.sa          = swap ? t.da : t.sa;
      w.sp          = swap ? t.dp : t.sp;
      w.da          = swap ? t.sa : t.da;
      w.dp          = swap ? t.sp : t.dp;
      w.flags       = flags;
      w.drain_first = ($urandom_range(99) < 2);
      hdr_backlog.push_back(w);
   endfunction

   function automatic void queue_tcp(tuple_type t, bit swap, logic [7:0] kind);
      queue_packet(PROTO_TCP, t, swap, kind | spare_flag_bits());
   endfunction

   // mostly complete handshakes on a small pool of tuples, some cut short
   // or started midway, plus random noise words
   function automatic void queue_mixed_traffic(int target);
      tuple_type pool [48];
      tuple_type t;
      int        made;
      int        n;
      int        first;
      int        last;
      bit        client;
      bit        closer;
      for (int i = 0; i < 48; i++) pool[i] = random_tuple();
      pool[0] = '1;   // extremes, both also match themselves swapped
      pool[1] = '0;
      made = 0;
      while (made < target) begin
         t = pool[$urandom_range(47)];
         if ($urandom_range(99) < 15) begin
            queue_packet($urandom_range(1) ? PROTO_TCP : 8'($urandom), t,
                         1'($urandom_range(1)), 8'($urandom));
            continue;
         end
         n      = hdr_backlog.size();
         client = 1'($urandom_range(1));
         closer = 1'($urandom_range(1));
         first  = 0;
         last   = 6;
         if ($urandom_range(99) < 30) begin
            first = $urandom_range(6);
            last  = $urandom_range(6, first);
         end
         for (int stage = first; stage <= last; stage++) begin
            case (stage)
               0: queue_tcp(t, client, FLAG_SYN);
               1: repeat ($urandom_range(4)) queue_tcp(t, client, FLAG_SYN);
               2: queue_tcp(t, !client, FLAG_SYN | FLAG_ACK);
               3: queue_tcp(t, client, FLAG_ACK);
               4: queue_tcp(t, closer, fin_kind());
               5: queue_tcp(t, !closer, fin_kind());
               default: queue_tcp(t, 1'($urandom_range(1)), FLAG_ACK);
            endcase
         end
         made += hdr_backlog.size() - n;
      end
   endfunction

   // overfill the table with fresh SYNs, close everything again, then
   // drive one tuple's retry count into saturation
   function automatic void queue_table_fill();
      tuple_type fresh [SLOTS + 6];
      tuple_type t;
      for (int i = 0; i < SLOTS + 6; i++) begin
         fresh[i] = random_tuple();
         queue_tcp(fresh[i], FWD, FLAG_SYN);
      end
      for (int i = 0; i < SLOTS + 6; i++) begin
         queue_tcp(fresh[i], FWD, fin_kind());
         queue_tcp(fresh[i], REV, fin_kind());
         queue_tcp(fresh[i], FWD, FLAG_ACK);
      end
      t = random_tuple();
      repeat (130) queue_tcp(t, FWD, FLAG_SYN);
      queue_tcp(t, FWD, FLAG_FIN);
      queue_tcp(t, REV, FLAG_FIN);
      queue_tcp(t, FWD, FLAG_ACK);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: one word per accept; stalls at random and, for flagged words,
   // until every outstanding result has come back
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      bit took;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took = start && !busy;
         if (took) begin
            predicted_results.push_back(track_header(on_wire));
            words_in++;
         end
         if (!start || took) begin
            if (hdr_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(hdr_backlog[0].drain_first && predicted_results.size() != 0)) begin
               on_wire = hdr_backlog.pop_front();
               if (on_wire.drain_first) drain_pauses++;
               start           <= 1'b1;
               req_ip_protocol <= on_wire.proto;
               req_src_addr    <= on_wire.sa;
               req_dst_addr    <= on_wire.da;
               req_src_port    <= on_wire.sp;
               req_dst_port    <= on_wire.dp;
               req_tcp_flags   <= on_wire.flags;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every rsp_valid word against the oldest prediction
   // ------------------------------------------------------------------------
   task automatic note_mismatch(string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         note_mismatch($sformatf("result word %0d %s: got 0x%0h, want 0x%0h",
                                 results_seen, name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_outcome < 11) outcome_hits[rsp_outcome]++;
         if (predicted_results.size() == 0) begin
            note_mismatch($sformatf("result word %0d arrived with nothing pending",
                                    results_seen));
         end else begin
            due = predicted_results.pop_front();
            check_field("outcome",  32'(rsp_outcome),          32'(due.outcome));
            check_field("slot",     32'(rsp_slot),             32'(due.slot));
            check_field("reversed", 32'(rsp_matched_reversed), 32'(due.reversed));
            check_field("state",    32'(rsp_conn_state),       32'(due.data.state));
            check_field("status",   32'(rsp_conn_status),      32'(due.data.status));
            check_field("retries",  32'(rsp_retry_count),      32'(due.data.retries));
            check_field("flags",    32'(rsp_stored_flags),     32'(due.data.flags));
         end
      end
   end

   // watchdog: ends a hung run
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, predicted_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------------

   // all words sent and answered, then a settling wait for stray results
   task automatic wait_until_drained();
      do @(negedge clock);
      while (hdr_backlog.size() != 0 || start || predicted_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_retry_limit(input logic [6:0] limit);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      retry_limit = limit;
      limit_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      tuple_type a;
      tuple_type b;
      tuple_type c;
      tuple_type d;
      int        codes_hit;

      a = '{sa: 32'hFFFF_FFFF, sp: 16'hFFFF, da: 32'h0, dp: 16'h0};
      b = '{sa: 32'h0A00_0001, sp: 16'd1234, da: 32'hC0A8_0001, dp: 16'd80};
      c = '{sa: 32'h8000_0000, sp: 16'h8000, da: 32'h7FFF_FFFF, dp: 16'h7FFF};
      d = random_tuple();

      // directed words, reset retry limit, empty table
      queue_packet(8'h11, a, FWD, FLAG_SYN);                // not TCP
      queue_packet(8'hFF, a, FWD, FLAG_SYN);
      queue_packet(PROTO_TCP, a, FWD, 8'h00);               // no flags
      queue_packet(PROTO_TCP, a, FWD, 8'hFF);               // all flags
      queue_packet(PROTO_TCP, a, FWD, FLAG_SYN | FLAG_FIN); // unknown mix
      queue_packet(PROTO_TCP, a, FWD, FLAG_ACK);            // nothing to find
      queue_packet(PROTO_TCP, a, FWD, FLAG_SYN | 8'hE0);    // create
      queue_packet(PROTO_TCP, a, FWD, FLAG_SYN);            // retry
      queue_packet(PROTO_TCP, a, REV, FLAG_SYN | FLAG_ACK); // advance
      queue_packet(PROTO_TCP, a, FWD, FLAG_ACK);            // connected
      queue_packet(PROTO_TCP, a, FWD, FLAG_FIN);            // fin1
      queue_packet(PROTO_TCP, a, REV, FLAG_FIN | FLAG_ACK); // fin2, swapped hit
      queue_packet(PROTO_TCP, a, REV, FLAG_ACK);            // closed, freed
      // SYN+ACK with no entry, then again on a non-SYN entry
      queue_packet(PROTO_TCP, b, REV, FLAG_SYN | FLAG_ACK);
      hdr_backlog[$].drain_first = 1'b1;                    // hold until idle
      queue_packet(PROTO_TCP, b, REV, FLAG_SYN | FLAG_ACK);
      // FIN with no entry, toggling, ACK with no effect
      queue_packet(PROTO_TCP, c, FWD, FLAG_FIN);
      queue_packet(PROTO_TCP, c, FWD, FLAG_FIN);
      queue_packet(PROTO_TCP, c, REV, FLAG_FIN);
      queue_packet(PROTO_TCP, c, REV, FLAG_ACK);
      // retries up to the reset limit; state survives the failure
      repeat (7) queue_packet(PROTO_TCP, d, FWD, FLAG_SYN);
      queue_packet(PROTO_TCP, d, REV, FLAG_SYN | FLAG_ACK);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_until_drained();

      // no idling, every retry fails
      write_retry_limit(7'd0);
      @(negedge clock);
      queue_mixed_traffic(300);
      wait_until_drained();

      // sender idle most of the time, limit at its top
      write_retry_limit(7'd127);
      @(negedge clock);
      send_idle_pct = 71;
      queue_table_fill();
      wait_until_drained();

      // receiver stall phase: results cannot be held off, so sender runs free
      write_retry_limit(7'($urandom_range(1, 10)));
      @(negedge clock);
      send_idle_pct = 0;
      queue_mixed_traffic(300);
      wait_until_drained();

      // sender idling lightly
      write_retry_limit(7'd5);
      @(negedge clock);
      send_idle_pct = 16;
      queue_mixed_traffic(300);
      wait_until_drained();

      codes_hit = 0;
      foreach (outcome_hits[i]) if (outcome_hits[i] != 0) codes_hit++;
      $display("Run: %0d header words, %0d result words checked, %0d limit writes, %0d drain holds",
               words_in, results_seen, limit_writes, drain_pauses);
      $display("Outcome codes seen: %0d of 11, table-full results: %0d",
               codes_hit, outcome_hits[OC_FULL]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== tcp_connection_tracker_unit.f =====
hw/rtl/ctu_pkg.sv
hw/rtl/ctu_prienc.sv
hw/rtl/ctu_cell.sv
hw/rtl/tcp_connection_tracker_unit.sv
test/tcp_connection_tracker_unit_tb.sv
